@@ sv/sha1_message_hasher_top_assert.svh @@
// assertion macros for the sha1 message hasher checker
`ifndef SHA1_MESSAGE_HASHER_TOP_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHA1MH_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHA1MH_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sha1mh_pkg.sv @@
`default_nettype none

package sha1mh_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] chain_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	typedef struct packed {
		logic wr_byte;
		logic pad;
		logic zero;
		logic len;
		logic shift;
	} sched_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	localparam chain_t IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
		32'hefcdab89, 32'h67452301};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [5:0] LAST_BYTE_POS = 6'd63;
	localparam logic [5:0] LEN_BYTE_POS = 6'd56;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

`default_nettype wire

@@ sv/sha1_message_hasher_top.sv @@
// sha1 hasher, one message byte per transfer, five digest words out per message
// byte that does not fill a block: the next transfer can follow on the next cycle
// byte that fills a block: the next transfer waits for the rounds and the add
// last transfer: one or two compressions (setup, rounds, add), then 5 words
// long messages: no new byte is taken while the round unit compresses a block
// async active-low reset: initial vector loaded, byte count zero, idle
`default_nettype none

module sha1_message_hasher_top (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     msg_valid,
	output logic                    msg_stall,
	input  sha1mh_pkg::msg_item_t   msg,
	output logic                    dig_valid,
	input  wire                     dig_stall,
	output sha1mh_pkg::dig_item_t   dig
);
	import sha1mh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_LEN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [63:0] total_q;
	logic [2:0]  idx_q;
	logic        last_q;
	logic        ext_q;
	logic        fin_q;
	chain_t      chain_q;

	logic        msg_fire;
	logic        dig_fire;
	logic        block_full;
	logic        short_pad;
	sched_ctl_t  sched_ctl;
	round_ctl_t  round_ctl;
	word_t       w;
	chain_t      vars;
	logic [6:0]  rnd_cnt_q;

	assign msg_stall  = (state_q != ST_IDLE);
	assign msg_fire   = msg_valid && !msg_stall;
	assign dig_valid  = (state_q == ST_OUT);
	assign dig_fire   = dig_valid && !dig_stall;
	assign block_full = msg.has_byte && (total_q[5:0] == LAST_BYTE_POS);
	assign short_pad  = (total_q[5:0] < LEN_BYTE_POS);

	assign dig.digest_word = chain_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == LAST_WORD_IDX);

	always_comb begin
		sched_ctl.wr_byte = msg_fire && msg.has_byte;
		sched_ctl.pad     = (state_q == ST_PAD);
		sched_ctl.zero    = (state_q == ST_LEN);
		sched_ctl.len     = ((state_q == ST_PAD) && short_pad) || (state_q == ST_LEN);
		sched_ctl.shift   = (state_q == ST_RUN);
		round_ctl.load    = (msg_fire && block_full) || (state_q == ST_PAD)
			|| (state_q == ST_LEN);
		round_ctl.step    = (state_q == ST_RUN);
	end

	sha1mh_sched u_sched (
		.clk       (clk),
		.ctl       (sched_ctl),
		.pos       (total_q[5:0]),
		.data_byte (msg.data_byte),
		.bit_len   ({total_q[60:0], 3'b000}),
		.w         (w)
	);

	sha1mh_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (round_ctl),
		.init   (chain_q),
		.w      (w),
		.vars   (vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			idx_q     <= '0;
			last_q    <= 1'b0;
			ext_q     <= 1'b0;
			fin_q     <= 1'b0;
			rnd_cnt_q <= '0;
			chain_q   <= IV;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_fire) begin
						if (msg.has_byte) begin
							total_q <= total_q + 64'd1;
						end
						last_q <= msg.last_byte;
						fin_q  <= 1'b0;
						if (block_full) begin
							rnd_cnt_q <= '0;
							state_q   <= ST_RUN;
						end else if (msg.last_byte) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					last_q    <= 1'b0;
					ext_q     <= !short_pad;
					fin_q     <= short_pad;
					rnd_cnt_q <= '0;
					state_q   <= ST_RUN;
				end
				ST_LEN: begin
					ext_q     <= 1'b0;
					fin_q     <= 1'b1;
					rnd_cnt_q <= '0;
					state_q   <= ST_RUN;
				end
				ST_RUN: begin
					rnd_cnt_q <= rnd_cnt_q + 7'd1;
					if (rnd_cnt_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + vars[i];
					end
					priority if (fin_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (ext_q) begin
						state_q <= ST_LEN;
					end else if (last_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_fire) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_WORD_IDX) begin
							chain_q <= IV;
							total_q <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/sha1mh_sched.sv @@
`default_nettype none

module sha1mh_sched (
	input  wire                     clk,
	input  sha1mh_pkg::sched_ctl_t  ctl,
	input  wire [5:0]               pos,
	input  wire [7:0]               data_byte,
	input  wire [63:0]              bit_len,
	output sha1mh_pkg::word_t       w
);
	import sha1mh_pkg::*;

	word_t win_q [16];
	word_t win_d [16];
	word_t w_new;

	assign w_new = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
	assign w = win_q[0];

	always_comb begin
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 16; i++) begin
			win_d[i] = win_q[i];
		end
		if (ctl.shift) begin
			for (int i = 0; i < 15; i++) begin
				win_d[i] = win_q[i + 1];
			end
			win_d[15] = w_new;
		end else begin
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 4; j++) begin
					p = 6'(4 * i + j);
					if (ctl.zero) begin
						win_d[i][8 * (3 - j) +: 8] = 8'h00;
					end else if (ctl.wr_byte && p == pos) begin
						win_d[i][8 * (3 - j) +: 8] = data_byte;
					end else if (ctl.pad && p == pos) begin
						win_d[i][8 * (3 - j) +: 8] = PAD_MARK;
					end else if (ctl.pad && p > pos) begin
						win_d[i][8 * (3 - j) +: 8] = 8'h00;
					end
				end
			end
			if (ctl.len) begin
				win_d[14] = bit_len[63:32];
				win_d[15] = bit_len[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			win_q[i] <= win_d[i];
		end
	end

endmodule

`default_nettype wire

@@ sv/sha1mh_round.sv @@
`default_nettype none

module sha1mh_round (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sha1mh_pkg::round_ctl_t  ctl,
	input  sha1mh_pkg::chain_t      init,
	input  sha1mh_pkg::word_t       w,
	output sha1mh_pkg::chain_t      vars
);
	import sha1mh_pkg::*;

	chain_t     vars_q;
	logic [6:0] rnd_q;
	word_t      f;
	word_t      k;
	word_t      tmp;
	word_t      b;
	word_t      c;
	word_t      d;

	assign b = vars_q[1];
	assign c = vars_q[2];
	assign d = vars_q[3];

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f = ((c ^ d) & b) ^ d;
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b & c) | (d & (b ^ c));
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
	end

	assign tmp = rotl(vars_q[0], 5) + f + vars_q[4] + k + w;
	assign vars = vars_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (ctl.load) begin
			rnd_q <= '0;
		end else if (ctl.step) begin
			rnd_q <= rnd_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			vars_q <= init;
		end else if (ctl.step) begin
			vars_q[4] <= d;
			vars_q[3] <= c;
			vars_q[2] <= rotl(b, 30);
			vars_q[1] <= vars_q[0];
			vars_q[0] <= tmp;
		end
	end

endmodule

`default_nettype wire

@@ sv/sha1mh_checker.sv @@
`default_nettype none
`include "sha1_message_hasher_top_assert.svh"

module sha1mh_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     msg_valid,
	input wire                     msg_stall,
	input sha1mh_pkg::msg_item_t   msg,
	input wire                     dig_valid,
	input wire                     dig_stall,
	input sha1mh_pkg::dig_item_t   dig
);
	import sha1mh_pkg::*;

	// no new message transfer while a digest is going out
	`SHA1MH_AST_IMP(a_busy_out, dig_valid, msg_stall, "input taken during digest output")
	// digest output starts at word zero
	`SHA1MH_AST_IMP(a_first_idx, $rose(dig_valid), dig.word_index == 3'd0, "digest not from word 0")
	// words follow in order without gaps
	`SHA1MH_AST_NXT(a_idx_step, dig_valid && !dig_stall && !dig.last_word, dig_valid && (dig.word_index == $past(dig.word_index) + 3'd1), "digest word order broken")
	// digest ends after the fifth word
	`SHA1MH_AST_NXT(a_end_out, dig_valid && !dig_stall && dig.last_word, !dig_valid, "extra digest word")
	// stalled word holds
	`SHA1MH_AST_NXT(a_hold, dig_valid && dig_stall, dig_valid && $stable(dig), "stalled digest changed")

endmodule

bind sha1_message_hasher_top sha1mh_checker u_sha1mh_checker (.*);

`default_nettype wire
